### hw/rtl/carp_pkg.sv
// carp_pkg: shared types, constants and hash helpers for the weighted hash peer selector
// no dependencies; used by every module of the block

package carp_pkg;

  localparam int HASH_W      = 32;
  localparam int IDX_W       = 3;
  localparam int BYTE_W      = 8;
  localparam int MASK_W      = 8;
  localparam int CNT_W       = 4;
  localparam int ROT_STEP    = 19;
  localparam int ROT_FINISH  = 21;
  localparam logic [HASH_W-1:0] HASH_MUL = 32'h6253_1965;

  typedef enum logic [1:0] {
    OP_NAME = 2'd0,
    OP_MULT = 2'd1,
    OP_KEY  = 2'd2
  } op_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] selected_peer;
    logic             busy;
  } sel_status_t;

  function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] x, input int n);
    return (x << n) | (x >> (HASH_W - n));
  endfunction

  // acc + rotl(acc, 19) + sign-extended byte, mod 2^32
  function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] sx;
    sx = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
    return acc + rotl(acc, ROT_STEP) + sx;
  endfunction

endpackage

### hw/rtl/carp_if.sv
// carp_if: request, result and configuration channels of the peer selector
// depends on carp_pkg for field widths

interface carp_req_if #(parameter int MULT_W = 20);
  logic                              valid;
  logic                              ready;
  logic [1:0]                        op;
  logic [carp_pkg::IDX_W-1:0]        peer_index;
  logic [carp_pkg::BYTE_W-1:0]       data_byte;
  logic                              last;
  logic [MULT_W-1:0]                 multiplier;
  logic [carp_pkg::MASK_W-1:0]       eligible_mask;

  modport source (output valid, op, peer_index, data_byte, last, multiplier, eligible_mask,
                  input ready);
  modport sink   (input valid, op, peer_index, data_byte, last, multiplier, eligible_mask,
                  output ready);
endinterface

interface carp_res_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [carp_pkg::IDX_W-1:0] selected_peer;

  modport source (output valid, found, selected_peer, input ready);
  modport sink   (input valid, found, selected_peer, output ready);
endinterface

interface carp_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [carp_pkg::CNT_W-1:0] peer_count;

  modport source (output valid, peer_count, input ready);
  modport sink   (input valid, peer_count, output ready);
endinterface

### hw/rtl/carp_peer_mem.sv
// carp_peer_mem: peer hash and load multiplier memories, one write and one read port each
// registered read data; depends on carp_pkg

module carp_peer_mem #(
  parameter int DEPTH  = 8,
  parameter int AW     = 3,
  parameter int MULT_W = 20
) (
  input  logic                        clk,
  input  logic                        hash_we,
  input  logic [AW-1:0]               hash_waddr,
  input  logic [carp_pkg::HASH_W-1:0] hash_wdata,
  input  logic                        mult_we,
  input  logic [AW-1:0]               mult_waddr,
  input  logic [MULT_W-1:0]           mult_wdata,
  input  logic [AW-1:0]               raddr,
  output logic [carp_pkg::HASH_W-1:0] rd_hash,
  output logic [MULT_W-1:0]           rd_mult
);

  logic [carp_pkg::HASH_W-1:0] hash_mem [DEPTH];
  logic [MULT_W-1:0]           mult_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (hash_we) begin
      hash_mem[hash_waddr] <= hash_wdata;
    end
    rd_hash <= hash_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (mult_we) begin
      mult_mem[mult_waddr] <= mult_wdata;
    end
    rd_mult <= mult_mem[raddr];
  end

endmodule

### hw/rtl/carp_finish.sv
// carp_finish: hash finisher h += h * 0x62531965, then rotate left by 21
// one register stage after the multiply; depends on carp_pkg

module carp_finish (
  input  logic                        clk,
  input  logic [carp_pkg::HASH_W-1:0] h_in,
  output logic [carp_pkg::HASH_W-1:0] h_out
);

  logic [carp_pkg::HASH_W-1:0] h_r;
  logic [carp_pkg::HASH_W-1:0] p_r;
  logic [carp_pkg::HASH_W-1:0] prod;

  // only the low word of the product is kept
  assign prod = h_in * carp_pkg::HASH_MUL;

  always_ff @(posedge clk) begin
    h_r <= h_in;
    p_r <= prod;
  end

  assign h_out = carp_pkg::rotl(h_r + p_r, carp_pkg::ROT_FINISH);

endmodule

### hw/rtl/carp_select.sv
// carp_select: scores each peer as finished hash times multiplier and keeps the best
// two register stages then a running max; depends on carp_pkg

module carp_select #(
  parameter int MULT_W = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        in_v,
  input  logic [carp_pkg::HASH_W-1:0] in_hash,
  input  logic [MULT_W-1:0]           in_mult,
  input  logic [carp_pkg::IDX_W-1:0]  in_idx,
  output carp_pkg::sel_status_t       status
);

  localparam int SCORE_W = carp_pkg::HASH_W + MULT_W;

  logic                        c_v;
  logic [carp_pkg::HASH_W-1:0] c_hash;
  logic [MULT_W-1:0]           c_mult;
  logic [carp_pkg::IDX_W-1:0]  c_idx;
  logic                        p_v;
  logic [SCORE_W-1:0]          prod;
  logic [carp_pkg::IDX_W-1:0]  p_idx;
  logic [SCORE_W-1:0]          best;
  logic [carp_pkg::IDX_W-1:0]  sel;
  logic                        found;

  always_ff @(posedge clk) begin
    c_hash <= in_hash;
    c_mult <= in_mult;
    c_idx  <= in_idx;
    prod   <= SCORE_W'(c_hash) * SCORE_W'(c_mult);
    p_idx  <= c_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
      p_v <= 1'b0;
    end else begin
      c_v <= in_v;
      p_v <= c_v;
    end
  end

  // strict compare keeps the first peer on ties and needs a score above zero
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      sel   <= '0;
      best  <= '0;
    end else if (start) begin
      found <= 1'b0;
      sel   <= '0;
      best  <= '0;
    end else if (p_v && (prod > best)) begin
      found <= 1'b1;
      sel   <= p_idx;
      best  <= prod;
    end
  end

  assign status.found         = found;
  assign status.selected_peer = sel;
  assign status.busy          = c_v | p_v;

  a_found_has_score: assert property (@(posedge clk) disable iff (rst)
    found |-> (best != '0)) else $error("found set with zero best score");
  a_no_score_no_found: assert property (@(posedge clk) disable iff (rst)
    $past(start) |-> !found && (sel == '0)) else $error("selection not cleared on start");
  a_sel_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(found) |-> $past(p_v)) else $error("found rose without a scored peer");

endmodule

### hw/rtl/carp_weighted_hash_peer_select_core.sv
// carp_weighted_hash_peer_select_core: top level of the weighted hash peer selector
// depends on carp_pkg, carp_if, carp_peer_mem, carp_finish and carp_select

// Peer name bytes, multiplier writes and non-final key bytes are taken one per cycle while the
// state is idle. After a final name byte the request port drops ready through states NAME1 and
// NAME2 while the hash finisher's multiplier runs and the hash is written to the peer memory. A
// final key byte walks the active peers through the single read port of the peer memory, one
// peer per cycle, then drains the finish, score and compare stages. It walks peers 0 to n - 1
// with n = min(peer_count, MAX_PEERS, 8), and goes straight to the result when n is 0. The result
// sits in an output register; further requests are taken while it waits, unless the next final
// key byte finishes scoring first. The peer tables read as undefined until written.
module carp_weighted_hash_peer_select_core #(
  parameter int MAX_PEERS      = 8,
  parameter int MULT_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  carp_req_if.sink   req,
  carp_res_if.source res,
  carp_cfg_if.sink   cfg
);

  localparam int MULT_W   = 4 + MULT_FRAC_BITS;
  localparam int AW       = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int SCAN_LIM = (MAX_PEERS < carp_pkg::MASK_W) ? MAX_PEERS : carp_pkg::MASK_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_NAME1 = 6'b000010,
    ST_NAME2 = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  function automatic logic [AW-1:0] to_addr(input logic [carp_pkg::IDX_W-1:0] i);
    logic [AW+carp_pkg::IDX_W-1:0] w;
    w = (AW+carp_pkg::IDX_W)'(i);
    return w[AW-1:0];
  endfunction

  state_t                       state, state_next;
  logic [carp_pkg::CNT_W-1:0]   peer_count;
  logic [carp_pkg::HASH_W-1:0]  name_acc;
  logic [carp_pkg::HASH_W-1:0]  key_acc;
  logic [carp_pkg::HASH_W-1:0]  hold_hash;
  logic [carp_pkg::IDX_W-1:0]   name_idx;
  logic [carp_pkg::MASK_W-1:0]  mask_r;
  logic [carp_pkg::CNT_W-1:0]   scan_n;
  logic [carp_pkg::IDX_W-1:0]   scan_idx;
  logic                         s0_v, s1_v;
  logic [carp_pkg::IDX_W-1:0]   s0_idx, s1_idx;
  logic [MULT_W-1:0]            s1_mult;
  logic                         res_v;
  logic                         res_found;
  logic [carp_pkg::IDX_W-1:0]   res_sel;

  carp_pkg::op_t                op;
  logic                         accept;
  logic                         key_done;
  logic                         name_done;
  logic [carp_pkg::HASH_W-1:0]  fold_val;
  logic [carp_pkg::CNT_W-1:0]   count_sat;
  logic                         scan_end;
  logic                         pipe_empty;
  logic                         res_load;
  logic                         hash_we, mult_we;
  logic [carp_pkg::HASH_W-1:0]  rd_hash;
  logic [MULT_W-1:0]            rd_mult;
  logic [carp_pkg::HASH_W-1:0]  fin_in, fin_out;
  carp_pkg::sel_status_t        sel_st;

  assign op        = carp_pkg::op_t'(req.op);
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign key_done  = accept && (op == carp_pkg::OP_KEY) && req.last;
  assign name_done = accept && (op == carp_pkg::OP_NAME) && req.last;
  assign fold_val  = carp_pkg::fold_byte((op == carp_pkg::OP_NAME) ? name_acc : key_acc,
                                         req.data_byte);
  assign count_sat = (int'(peer_count) > SCAN_LIM) ? carp_pkg::CNT_W'(SCAN_LIM) : peer_count;
  assign scan_end  = ({1'b0, scan_idx} == (scan_n - 1'b1));
  assign pipe_empty = !s0_v && !s1_v && !sel_st.busy;
  assign res_load  = (state == ST_DONE) && (!res_v || res.ready);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_count <= '0;
    end else if (cfg.valid) begin
      peer_count <= cfg.peer_count;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (name_done) begin
          state_next = ST_NAME1;
        end else if (key_done) begin
          state_next = (count_sat == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_NAME1: state_next = ST_NAME2;
      ST_NAME2: state_next = ST_IDLE;
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      name_acc <= '0;
      key_acc  <= '0;
      scan_idx <= '0;
      s0_v     <= 1'b0;
      s1_v     <= 1'b0;
      res_v    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (op == carp_pkg::OP_NAME)) begin
        name_acc <= req.last ? '0 : fold_val;
      end
      if (accept && (op == carp_pkg::OP_KEY)) begin
        key_acc <= req.last ? '0 : fold_val;
      end
      if (key_done) begin
        scan_idx <= '0;
      end else if (state == ST_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
      end
      s0_v <= (state == ST_SCAN) && mask_r[scan_idx];
      s1_v <= s0_v;
      if (res_load) begin
        res_v <= 1'b1;
      end else if (res.ready) begin
        res_v <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (name_done || key_done) begin
      hold_hash <= fold_val;
    end
    if (name_done) begin
      name_idx <= req.peer_index;
    end
    if (key_done) begin
      mask_r <= req.eligible_mask;
      scan_n <= count_sat;
    end
    s0_idx  <= scan_idx;
    s1_idx  <= s0_idx;
    s1_mult <= rd_mult;
    if (res_load) begin
      res_found <= sel_st.found;
      res_sel   <= sel_st.selected_peer;
    end
  end

  // table writes happen only outside the scan, so reads never see a write in flight
  assign hash_we = (state == ST_NAME2) && (int'(name_idx) < MAX_PEERS);
  assign mult_we = accept && (op == carp_pkg::OP_MULT) && (int'(req.peer_index) < MAX_PEERS);

  carp_peer_mem #(
    .DEPTH  (MAX_PEERS),
    .AW     (AW),
    .MULT_W (MULT_W)
  ) u_mem (
    .clk        (clk),
    .hash_we    (hash_we),
    .hash_waddr (to_addr(name_idx)),
    .hash_wdata (fin_out),
    .mult_we    (mult_we),
    .mult_waddr (to_addr(req.peer_index)),
    .mult_wdata (req.multiplier),
    .raddr      (to_addr(scan_idx)),
    .rd_hash    (rd_hash),
    .rd_mult    (rd_mult)
  );

  // the finisher is shared by name hashing and peer scoring
  assign fin_in = (state == ST_NAME1) ? hold_hash : (hold_hash ^ rd_hash);

  carp_finish u_fin (
    .clk   (clk),
    .h_in  (fin_in),
    .h_out (fin_out)
  );

  carp_select #(
    .MULT_W (MULT_W)
  ) u_sel (
    .clk     (clk),
    .rst     (rst),
    .start   (key_done),
    .in_v    (s1_v),
    .in_hash (fin_out),
    .in_mult (s1_mult),
    .in_idx  (s1_idx),
    .status  (sel_st)
  );

  assign res.valid         = res_v;
  assign res.found         = res_found;
  assign res.selected_peer = res_sel;

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> pipe_empty) else $error("scan pipeline busy while idle");
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) || (state == ST_DRAIN)) |-> !hash_we && !mult_we)
    else $error("peer table written during scan");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_v) |-> $past(state == ST_DONE)) else $error("result loaded outside done");
  a_key_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    key_done |=> (state != ST_IDLE)) else $error("final key byte did not start a scan");

endmodule

### tb/carp_weighted_hash_peer_select_core_test.sv
`timescale 1ns / 1ps
// self-checking test of carp_weighted_hash_peer_select_core: peer names, multipliers and request
// keys go in, each final key byte is scored here and the selection is compared with the block's
// depends on carp_pkg, carp_if and the core itself

module carp_weighted_hash_peer_select_core_test;

  localparam int HASH_W         = carp_pkg::HASH_W;
  localparam int IDX_W          = carp_pkg::IDX_W;
  localparam int BYTE_W         = carp_pkg::BYTE_W;
  localparam int MASK_W         = carp_pkg::MASK_W;
  localparam int CNT_W          = carp_pkg::CNT_W;
  localparam logic [HASH_W-1:0] HASH_MUL = carp_pkg::HASH_MUL;
  localparam int MAX_PEERS      = 8;
  localparam int MULT_FRAC_BITS = 16;
  localparam int MULT_W         = 4 + MULT_FRAC_BITS;
  localparam int SETTLE_CYCLES  = 32;
  localparam int HOLD_CYCLES    = 400;
  localparam int QUIET_LIMIT    = 3000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [MULT_W-1:0] MULT_ONE = 20'h10000;
  localparam logic [BYTE_W-1:0] TWIN_BYTE = 8'h5a;

  typedef struct {
    logic [1:0]        op;
    logic [IDX_W-1:0]  peer_index;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
    logic [MULT_W-1:0] multiplier;
    logic [MASK_W-1:0] eligible_mask;
  } peer_req_t;

  typedef struct {
    logic             found;
    logic [IDX_W-1:0] peer;
  } pick_t;

  logic clk;
  logic rst;

  carp_req_if #(.MULT_W(MULT_W)) req_if ();
  carp_res_if res_if ();
  carp_cfg_if cfg_if ();

  carp_weighted_hash_peer_select_core #(
    .MAX_PEERS(MAX_PEERS),
    .MULT_FRAC_BITS(MULT_FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .res(res_if),
    .cfg(cfg_if)
  );

  // mirror of the selector state
  logic [HASH_W-1:0] peer_hash [MAX_PEERS];
  logic [MULT_W-1:0] peer_mult [MAX_PEERS];
  logic [HASH_W-1:0] name_acc;
  logic [HASH_W-1:0] key_acc;
  logic [CNT_W-1:0]  peer_count;

  peer_req_t pending_reqs [$];
  pick_t     expected_picks [$];
  peer_req_t on_bus;

  bit gaps_on;
  int stall_requests;
  int stall_served;
  int hold_left;
  int quiet_cycles;
  int error_count;
  int reqs_queued;
  int reqs_accepted;
  int picks_checked;
  int picks_found;
  int cfg_writes;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [HASH_W-1:0] hash_fold(input logic [HASH_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] sx;
    sx = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
    return acc + {acc[12:0], acc[31:13]} + sx;
  endfunction

  function automatic logic [HASH_W-1:0] hash_finish(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] t;
    t = h + h * HASH_MUL;
    return {t[10:0], t[31:11]};
  endfunction

  // updates the mirror and, on a final key byte, works out the winning peer
  function automatic void apply_request(input peer_req_t r);
    logic [HASH_W-1:0] comb;
    logic [HASH_W+MULT_W-1:0] score;
    logic [HASH_W+MULT_W-1:0] best;
    int n;
    pick_t pick;
    case (r.op)
      carp_pkg::OP_NAME: begin
        name_acc = hash_fold(name_acc, r.data_byte);
        if (r.last) begin
          peer_hash[r.peer_index] = hash_finish(name_acc);
          name_acc = '0;
        end
      end
      carp_pkg::OP_MULT: peer_mult[r.peer_index] = r.multiplier;
      carp_pkg::OP_KEY: begin
        key_acc = hash_fold(key_acc, r.data_byte);
        if (r.last) begin
          best = '0;
          pick.found = 1'b0;
          pick.peer = '0;
          n = (peer_count > MAX_PEERS) ? MAX_PEERS : int'(peer_count);
          for (int i = 0; i < n; i++) begin
            if (r.eligible_mask[i]) begin
              comb = hash_finish(key_acc ^ peer_hash[i]);
              score = {{MULT_W{1'b0}}, comb} * {{HASH_W{1'b0}}, peer_mult[i]};
              if (score > best) begin
                best = score;
                pick.found = 1'b1;
                pick.peer = IDX_W'(i);
              end
            end
          end
          key_acc = '0;
          expected_picks = {expected_picks, pick};
        end
      end
      default: ;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        apply_request(on_bus);
        reqs_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() != 0 && !(gaps_on && $urandom_range(99) < 22)) begin
          on_bus = pending_reqs.pop_front();
          req_if.valid <= 1'b1;
          req_if.op <= on_bus.op;
          req_if.peer_index <= on_bus.peer_index;
          req_if.data_byte <= on_bus.data_byte;
          req_if.last <= on_bus.last;
          req_if.multiplier <= on_bus.multiplier;
          req_if.eligible_mask <= on_bus.eligible_mask;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor, also drives ready
  always @(posedge clk) begin
    pick_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (stall_served != stall_requests) begin
        stall_served <= stall_requests;
        hold_left <= HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= !(gaps_on && $urandom_range(99) < 22);
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_picks.size() == 0) begin
          $error("selection with none pending: found %0b selected_peer %0d",
                 res_if.found, res_if.selected_peer);
          error_count++;
        end else begin
          want = expected_picks.pop_front();
          picks_checked++;
          if (want.found) picks_found++;
          if (res_if.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, res_if.found);
            error_count++;
          end
          if (res_if.selected_peer !== want.peer) begin
            $error("selected_peer: expected %0d, got %0d", want.peer, res_if.selected_peer);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("carp_weighted_hash_peer_select_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_req(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [BYTE_W-1:0] b, input logic last,
                           input logic [MULT_W-1:0] m, input logic [MASK_W-1:0] mask);
    peer_req_t r;
    r.op = op;
    r.peer_index = idx;
    r.data_byte = b;
    r.last = last;
    r.multiplier = m;
    r.eligible_mask = mask;
    pending_reqs = {pending_reqs, r};
    if (op != OP_UNUSED) reqs_queued++;
  endtask

  // only the final byte's peer_index matters, the others carry noise
  task automatic queue_name(input logic [IDX_W-1:0] idx, input int nbytes);
    for (int k = 0; k < nbytes; k++) begin
      queue_req(carp_pkg::OP_NAME, (k == nbytes - 1) ? idx : IDX_W'($urandom_range(7)),
                BYTE_W'($urandom), k == nbytes - 1, MULT_W'($urandom), MASK_W'($urandom));
    end
  endtask

  task automatic queue_key(input int nbytes, input logic [MASK_W-1:0] mask);
    for (int k = 0; k < nbytes; k++) begin
      queue_req(carp_pkg::OP_KEY, IDX_W'($urandom), BYTE_W'($urandom), k == nbytes - 1,
                MULT_W'($urandom), (k == nbytes - 1) ? mask : MASK_W'($urandom));
    end
  endtask

  task automatic queue_mult(input logic [IDX_W-1:0] idx, input logic [MULT_W-1:0] m);
    queue_req(carp_pkg::OP_MULT, idx, BYTE_W'($urandom), 1'($urandom), m, MASK_W'($urandom));
  endtask

  function automatic logic [MULT_W-1:0] pick_mult();
    case ($urandom_range(7))
      0, 1: return '0;
      2: return '1;
      3: return MULT_ONE;
      default: return MULT_W'($urandom);
    endcase
  endfunction

  task automatic queue_mix(input int count);
    int start;
    int r;
    logic [IDX_W-1:0] idx;
    start = reqs_queued;
    while (reqs_queued - start < count) begin
      r = $urandom_range(99);
      idx = IDX_W'($urandom_range(7));
      if (r < 15) begin
        queue_name(idx, $urandom_range(1, 6));
      end else if (r < 20) begin
        // identical peers, so that ties come up
        queue_req(carp_pkg::OP_NAME, idx, TWIN_BYTE, 1'b1, MULT_W'($urandom),
                  MASK_W'($urandom));
        queue_mult(idx, MULT_ONE);
      end else if (r < 35) begin
        queue_mult(idx, pick_mult());
      end else if (r < 92) begin
        queue_key($urandom_range(1, 8), ($urandom_range(3) == 0) ? '1 : MASK_W'($urandom));
      end else begin
        queue_req(OP_UNUSED, idx, BYTE_W'($urandom), 1'($urandom), MULT_W'($urandom),
                  MASK_W'($urandom));
      end
    end
  endtask

  task automatic wait_all_done(input int extra);
    @(negedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || expected_picks.size() != 0)
      @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_peer_count(input logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.peer_count <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    peer_count = v;
    cfg_writes++;
    @(negedge clk);
  endtask

  initial begin
    logic [CNT_W-1:0] phase_counts [7];
    phase_counts = '{4'd9, 4'd3, 4'd8, 4'd15, 4'd0, 4'd8, 4'd1};
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.op = carp_pkg::OP_NAME;
    req_if.peer_index = '0;
    req_if.data_byte = '0;
    req_if.last = 1'b0;
    req_if.multiplier = '0;
    req_if.eligible_mask = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.peer_count = '0;
    name_acc = '0;
    key_acc = '0;
    peer_count = '0;
    gaps_on = 1'b1;
    stall_requests = 0;
    stall_served = 0;
    hold_left = 0;
    error_count = 0;
    reqs_queued = 0;
    reqs_accepted = 0;
    picks_checked = 0;
    picks_found = 0;
    cfg_writes = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // no active peers: nothing can be found
    write_peer_count('0);
    queue_req(carp_pkg::OP_KEY, '0, 8'h80, 1'b1, '0, '1);
    queue_req(OP_UNUSED, '1, '1, 1'b1, '1, '1);

    // fill every table entry before any peer is scored; peers 3 and 5 are identical
    queue_req(carp_pkg::OP_NAME, 3'd0, 8'h00, 1'b1, '1, '0);
    queue_req(carp_pkg::OP_NAME, 3'd1, 8'hff, 1'b1, '0, '1);
    queue_req(carp_pkg::OP_NAME, 3'd2, 8'h7f, 1'b1, '1, '0);
    queue_req(carp_pkg::OP_NAME, 3'd3, 8'h80, 1'b1, '0, '1);
    queue_req(carp_pkg::OP_NAME, 3'd4, 8'h01, 1'b1, '1, '0);
    queue_req(carp_pkg::OP_NAME, 3'd5, 8'h80, 1'b1, '0, '1);
    queue_req(carp_pkg::OP_NAME, 3'd6, 8'ha5, 1'b1, '1, '0);
    queue_name(3'd7, 3);
    queue_mult(3'd0, '0);
    queue_mult(3'd1, '1);
    queue_mult(3'd2, MULT_ONE);
    queue_mult(3'd3, 20'h30000);
    queue_mult(3'd4, 20'h08000);
    queue_mult(3'd5, 20'h30000);
    queue_mult(3'd6, 20'h00001);
    queue_mult(3'd7, pick_mult());
    wait_all_done(SETTLE_CYCLES);

    write_peer_count(CNT_W'(MAX_PEERS));
    queue_key(3, '1);
    queue_key(1, '0);
    queue_key(2, 8'h28);
    queue_key(1, 8'h01);

    for (int p = 0; p < 7; p++) begin
      wait_all_done(SETTLE_CYCLES);
      write_peer_count(phase_counts[p]);
      gaps_on = (p != 3);
      if (p == 5) begin
        // receiver holds off while short keys keep coming
        stall_requests++;
        for (int k = 0; k < 40; k++) queue_key($urandom_range(1, 2), '1);
      end
      if (p == 2) begin
        queue_mix(40);
        wait_all_done(0);
        queue_mix(40);
      end else begin
        queue_mix(85);
      end
    end
    wait_all_done(SETTLE_CYCLES);

    $display("run covered %0d requests and %0d peer_count writes (0, 8 and 15 among them)",
             reqs_accepted, cfg_writes);
    $display("%0d selections checked, %0d with a peer found, %0d mismatches",
             picks_checked, picks_found, error_count);
    if (error_count == 0) begin
      $display("carp_weighted_hash_peer_select_core regression: pass");
    end else begin
      $display("carp_weighted_hash_peer_select_core regression: fail");
    end
    $finish;
  end

endmodule
